/* design/rcb_pkg.sv */
// rcb_pkg: shared types, register indexes and fixed-point helpers for the
// RGB colour balance pipeline. No dependencies.
`timescale 1ns / 1ps

package rcb_pkg;

  localparam int unsigned CH_COUNT   = 3;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIFF_W     = PIX_W + 1;   // signed channel difference
  localparam int unsigned GAIN_W     = 11;          // gains carried as signed 11 bit
  localparam int unsigned PROD_W     = DIFF_W + GAIN_W;
  localparam int unsigned Q_W        = PROD_W - 8;  // product after Q8 scaling
  localparam int unsigned SUM_W      = 13;          // base plus scaled term
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned N_STAGES   = 8;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MID = 8'd128;

  // floor(s / 3) for s <= 765 as (s * 683) >> 11
  localparam logic [9:0] THIRD_RECIP = 10'd683;
  localparam int unsigned THIRD_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_HUE        = 2'd2,
    REG_SATURATION = 2'd3
  } cfg_reg_t;

  typedef logic [CH_COUNT-1:0][PIX_W-1:0]  pix_t;
  typedef logic [CH_COUNT-1:0][DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic en_mul;
    logic en_add;
  } lane_ctl_t;

  // Q8 scale with truncation toward zero
  function automatic logic signed [Q_W-1:0] q8_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    return adj[PROD_W-1:8];
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (v > $signed({5'd0, PIX_MAX})) begin
      res = PIX_MAX;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/rcb_lane.sv */
// rcb_lane: three-lane Q8 scale-and-offset unit, two register stages
// (product, then truncate/add/clamp). Depends on rcb_pkg.
`timescale 1ns / 1ps

module rcb_lane import rcb_pkg::*; (
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic signed [GAIN_W-1:0] gain,
  input  diff_t                    diff,
  input  pix_t                     base,
  output pix_t                     res
);

  logic signed [PROD_W-1:0] prod_r [CH_COUNT];
  pix_t                     base_r;
  pix_t                     res_r;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      for (int i = 0; i < CH_COUNT; i++) begin
        prod_r[i] <= $signed(diff[i]) * gain;
      end
      base_r <= base;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_add) begin
      for (int i = 0; i < CH_COUNT; i++) begin
        res_r[i] <= clamp_pix($signed({5'd0, base_r[i]}) +
                              SUM_W'(q8_trunc(prod_r[i])));
      end
    end
  end

  assign res = res_r;

endmodule

/* design/rgb_color_balance.sv */
// rgb_color_balance: brightness, contrast, hue and saturation on an RGB
// pixel stream. One word per cycle sustained while the output is not stalled;
// each stage holds a word and fills bubbles on a stall.
// Synchronous active-low reset clears the stage valids and restores the
// register defaults (offset 0, contrast and saturation unity, hue 0).
`timescale 1ns / 1ps

module rgb_color_balance import rcb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // red_out[7:0], green_out[15:8], blue_out[23:16]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [8:0] bright_r;
  logic [9:0]        contrast_r;
  logic signed [9:0] hue_r;
  logic [9:0]        sat_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r   <= '0;
      contrast_r <= 10'd256;
      hue_r      <= '0;
      sat_r      <= 10'd256;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BRIGHTNESS: bright_r   <= cfg_data[8:0];
        REG_CONTRAST:   contrast_r <= cfg_data;
        REG_HUE:        hue_r      <= cfg_data;
        REG_SATURATION: sat_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake: a stage moves when empty or when the next one moves
  logic [N_STAGES-1:0] v_r;
  logic [N_STAGES:0]   rdy;

  always_comb begin
    rdy[N_STAGES] = out_tready;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready = rdy[0];

  // stage 0: brightness
  pix_t bri_r;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < CH_COUNT; i++) begin
        bri_r[i] <= clamp_pix(SUM_W'($signed({1'b0, in_tdata[i*PIX_W +: PIX_W]})) +
                              SUM_W'(bright_r));
      end
    end
  end

  // stages 1-2: contrast about mid grey
  diff_t con_diff;
  pix_t  con_base;
  pix_t  con_res;
  always_comb begin
    for (int i = 0; i < CH_COUNT; i++) begin
      con_diff[i] = {1'b0, bri_r[i]} - {1'b0, PIX_MID};
      con_base[i] = PIX_MID;
    end
  end

  rcb_lane u_contrast (
    .clk  (clk),
    .ctl  (lane_ctl_t'{en_mul: rdy[1], en_add: rdy[2]}),
    .gain ($signed({1'b0, contrast_r})),
    .diff (con_diff),
    .base (con_base),
    .res  (con_res)
  );

  // stages 3-4: hue, cyclic differences of the other two channels
  diff_t hue_diff;
  pix_t  hue_res;
  always_comb begin
    for (int i = 0; i < CH_COUNT; i++) begin
      hue_diff[i] = {1'b0, con_res[(i+1)%CH_COUNT]} - {1'b0, con_res[(i+2)%CH_COUNT]};
    end
  end

  rcb_lane u_hue (
    .clk  (clk),
    .ctl  (lane_ctl_t'{en_mul: rdy[3], en_add: rdy[4]}),
    .gain ({hue_r[9], hue_r}),
    .diff (hue_diff),
    .base (con_res),
    .res  (hue_res)
  );

  // stage 5: truncated mean of the three channels
  pix_t       h_r;
  logic [7:0] mean_r;
  logic [9:0] sum3;
  logic [19:0] mean_prod;
  always_comb begin
    sum3      = 10'(hue_res[0]) + 10'(hue_res[1]) + 10'(hue_res[2]);
    mean_prod = 20'(sum3) * 20'(THIRD_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      h_r    <= hue_res;
      mean_r <= mean_prod[THIRD_SHIFT +: PIX_W];
    end
  end

  // stages 6-7: saturation about the mean
  diff_t sat_diff;
  pix_t  sat_base;
  pix_t  sat_res;
  always_comb begin
    for (int i = 0; i < CH_COUNT; i++) begin
      sat_diff[i] = {1'b0, h_r[i]} - {1'b0, mean_r};
      sat_base[i] = mean_r;
    end
  end

  rcb_lane u_saturation (
    .clk  (clk),
    .ctl  (lane_ctl_t'{en_mul: rdy[6], en_add: rdy[7]}),
    .gain ($signed({1'b0, sat_r})),
    .diff (sat_diff),
    .base (sat_base),
    .res  (sat_res)
  );

  assign out_tvalid = v_r[N_STAGES-1];
  assign out_tdata  = sat_res;

endmodule

/* design/rcb_checker.sv */
// rcb_checker: port-level assertions for rgb_color_balance, bound to the
// top level below. Needs only the top level's clock, reset, handshake and output ports.
`timescale 1ns / 1ps

module rcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // and does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // an empty or draining last stage leaves room at the input
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled although the pipe can advance");

endmodule

bind rgb_color_balance rcb_checker u_rcb_checker (.*);
